// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the median filter RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked on every clock edge out of reset
`define SPMF_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("spmf invariant violated");

// Same-cycle implication
`define SPMF_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spmf implication violated");

// Next-cycle implication
`define SPMF_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spmf next-cycle implication violated");

`endif

// ----- hdl/spmf_pkg.sv -----
// Shared types and constants of the selectable pixel median filter.
// No dependencies; used by every module of the block except spmf_ram.
`default_nettype none

package spmf_pkg;

	localparam int PIX_BITS = 8;
	localparam int CFG_BITS = 12;
	// row counter runs up to height + 1
	localparam int ROW_BITS = 13;

	localparam logic [CFG_BITS-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RST = 12'd480;

	typedef logic [PIX_BITS-1:0] pix_t;
	// 3x3 window, entry r*3+c, row 0 on top, column 0 on the left
	typedef pix_t [8:0] win_t;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	// code 3 has no name: the centre pixel passes through
	typedef enum logic [1:0] {
		MODE_MED3   = 2'd0,
		MODE_CROSS5 = 2'd1,
		MODE_BOX9   = 2'd2
	} mode_t;

	// where the result lies in the frame, worked out when the word enters
	typedef struct packed {
		logic emit;
		logic up;
		logic dn;
		logic lf;
		logic rt;
		logic line_end;
		logic frame_end;
	} geom_t;

endpackage

`default_nettype wire

// ----- hdl/spmf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module spmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents when both ports hit one address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/spmf_scan.sv -----
// Input stage: column/row counters, edge flags and the stage-1 register.
// Depends on spmf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spmf_scan #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             restart,
	input  wire logic                             in_fire,
	input  wire spmf_pkg::pix_t                   pixel_value,
	input  wire logic                             flush_item,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
	input  wire logic [spmf_pkg::CFG_BITS-1:0]    eff_height,
	input  wire logic                             s1_fire,
	output logic                                  in_ready,
	output logic      [$clog2(MAX_WIDTH)-1:0]     rd_addr,
	output logic                                  s1_valid,
	output logic      [$clog2(MAX_WIDTH)-1:0]     col_s1,
	output spmf_pkg::pix_t                        pix_s1,
	output spmf_pkg::geom_t                       geom_s1
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RB = spmf_pkg::ROW_BITS;

	logic [AW-1:0]  col_q;
	logic [RB-1:0]  row_q;
	logic           s1_valid_q;

	logic [AW-1:0]  ci;
	logic [CW-1:0]  ci_ext;
	logic [RB-1:0]  h_ext;
	logic [RB-1:0]  orow;
	logic           col_nz;
	logic           last_col;
	spmf_pkg::geom_t geom;
	spmf_pkg::pix_t  pix_in;

	// position of this word and of the result it releases
	always_comb begin
		ci       = (CW'(col_q) >= eff_width) ? '0 : col_q;
		ci_ext   = CW'(ci);
		col_nz   = (ci != '0);
		h_ext    = RB'(eff_height);
		orow     = col_nz ? (row_q - RB'(1)) : (row_q - RB'(2));
		last_col = (ci_ext == eff_width - CW'(1));

		geom.emit      = col_nz ? ((row_q != '0) && (row_q <= h_ext))
		                        : ((row_q >= RB'(2)) && (row_q <= h_ext + RB'(1)));
		geom.up        = (orow != '0);
		geom.dn        = (orow < h_ext - RB'(1));
		geom.lf        = col_nz ? (ci_ext > CW'(1)) : (eff_width != CW'(1));
		geom.rt        = col_nz;
		geom.line_end  = !col_nz;
		geom.frame_end = !col_nz && (row_q == h_ext + RB'(1));

		// flushes and words past the last line enter as zero
		pix_in = (flush_item || (row_q >= h_ext)) ? '0 : pixel_value;
	end

	assign rd_addr  = ci;
	assign in_ready = !s1_valid_q || s1_fire;
	assign s1_valid = s1_valid_q;

	// counters and stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (in_fire) begin
				if (geom.frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (last_col) begin
					col_q <= '0;
					row_q <= row_q + RB'(1);
				end else begin
					col_q <= ci + AW'(1);
				end
			end
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// stage-1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1  <= ci;
			pix_s1  <= pix_in;
			geom_s1 <= geom;
		end
	end

	`SPMF_ASSERT(a_row_bound, row_q <= h_ext + RB'(1))
	`SPMF_ASSERT(a_col_bound, CW'(col_q) < eff_width)

endmodule

`default_nettype wire

// ----- hdl/spmf_linebuf.sv -----
// Line stores, read forwarding and the 3x3 window register; stage 2 flags.
// Depends on spmf_pkg, spmf_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spmf_linebuf #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire logic                          in_fire,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  wire logic                          s1_valid,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  col_s1,
	input  wire spmf_pkg::pix_t                pix_s1,
	input  wire spmf_pkg::geom_t               geom_s1,
	input  wire logic                          out_free,
	output logic                               s1_fire,
	output logic                               s2_valid,
	output spmf_pkg::geom_t                    geom_s2,
	output spmf_pkg::win_t                     window
);

	spmf_pkg::pix_t a_rd, b_rd, a_cur, b_cur;
	spmf_pkg::pix_t fwd_a_q, fwd_b_q;
	logic           fwd_q;
	logic           clr_q;
	logic           s2_valid_q;
	logic           s2_adv;
	spmf_pkg::win_t win_q, win_old, win_nxt;

	// line before (a) and the line before that (b)
	spmf_ram #(.WIDTH(spmf_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_store_a (
		.clk     (clk),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (a_rd)
	);

	spmf_ram #(.WIDTH(spmf_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_store_b (
		.clk     (clk),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (a_cur),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (b_rd)
	);

	// one-pixel lines read the column that is being written in the same cycle
	assign a_cur = fwd_q ? fwd_a_q : a_rd;
	assign b_cur = fwd_q ? fwd_b_q : b_rd;

	assign s2_adv  = !s2_valid_q || out_free;
	assign s1_fire = s1_valid && s2_adv;

	// shift the window one column left, new column from stores and input
	always_comb begin
		win_old = clr_q ? '0 : win_q;
		win_nxt    = win_old;
		win_nxt[0] = win_old[1];
		win_nxt[1] = win_old[2];
		win_nxt[2] = b_cur;
		win_nxt[3] = win_old[4];
		win_nxt[4] = win_old[5];
		win_nxt[5] = a_cur;
		win_nxt[6] = win_old[7];
		win_nxt[7] = win_old[8];
		win_nxt[8] = pix_s1;
	end

	// control: forward flag, window clear, stage-2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q      <= 1'b0;
			clr_q      <= 1'b1;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				fwd_q <= s1_fire && (rd_addr == col_s1);
			end
			if (restart) begin
				clr_q <= 1'b1;
			end else if (s1_fire) begin
				clr_q <= geom_s1.frame_end;
			end
			if (s2_adv) begin
				s2_valid_q <= s1_fire && geom_s1.emit;
			end
		end
	end

	// payload: forwarded words, window, stage-2 flags
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fwd_a_q <= pix_s1;
			fwd_b_q <= a_cur;
		end
		if (s1_fire) begin
			win_q   <= win_nxt;
			geom_s2 <= geom_s1;
		end
	end

	assign s2_valid = s2_valid_q;
	assign window   = win_q;

	`SPMF_ASSERT_IMP(a_s2_emits, s2_valid_q, geom_s2.emit)
	`SPMF_ASSERT_NXT(a_frame_clear, s1_fire && geom_s1.frame_end && !restart, clr_q)

endmodule

`default_nettype wire

// ----- hdl/spmf_median.sv -----
// Median selection for the three modes (code 3 passes the centre pixel) and the output register.
// Depends on spmf_pkg.
`default_nettype none

module spmf_median (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire spmf_pkg::mode_t mode,
	input  wire logic            s2_valid,
	input  wire spmf_pkg::geom_t geom_s2,
	input  wire spmf_pkg::win_t  window,
	input  wire logic            m_tready,
	output logic                 out_free,
	output logic                 m_tvalid,
	output spmf_pkg::pix_t       median_value,
	output logic                 line_end,
	output logic                 frame_end
);

	function automatic spmf_pkg::pix_t pmin(spmf_pkg::pix_t a, spmf_pkg::pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic spmf_pkg::pix_t pmax(spmf_pkg::pix_t a, spmf_pkg::pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic spmf_pkg::pix_t pmed3(spmf_pkg::pix_t a, spmf_pkg::pix_t b,
	                                         spmf_pkg::pix_t c);
		return pmax(pmin(a, b), pmin(pmax(a, b), c));
	endfunction

	spmf_pkg::pix_t res;
	spmf_pkg::pix_t p_up, p_lf, p_c, p_rt, p_dn;
	spmf_pkg::pix_t s11, s12, s13, s14, s21, s22, s23, s24, x_hi, x_lo;
	spmf_pkg::pix_t g [3][3];
	spmf_pkg::pix_t r_lo [3];
	spmf_pkg::pix_t r_md [3];
	spmf_pkg::pix_t r_hi [3];
	logic [1:0]     rsel [3];
	logic [1:0]     csel [3];
	logic           m_tvalid_q;

	always_comb begin
		// zero-padded neighbors for modes 0 and 1
		p_up = geom_s2.up ? window[1] : '0;
		p_lf = geom_s2.lf ? window[3] : '0;
		p_c  = window[4];
		p_rt = geom_s2.rt ? window[5] : '0;
		p_dn = geom_s2.dn ? window[7] : '0;

		// cross network: max/min pairs, then median with the pixel below
		s11  = pmin(p_up, p_lf);
		s12  = pmax(p_up, p_lf);
		s13  = pmin(p_c, p_rt);
		s14  = pmax(p_c, p_rt);
		s21  = pmin(s11, s14);
		s22  = pmax(s11, s14);
		s23  = pmin(s12, s13);
		s24  = pmax(s12, s13);
		x_hi = pmax(s21, s23);
		x_lo = pmin(s22, s24);

		// edge replication for the full window
		rsel[0] = geom_s2.up ? 2'd0 : 2'd1;
		rsel[1] = 2'd1;
		rsel[2] = geom_s2.dn ? 2'd2 : 2'd1;
		csel[0] = geom_s2.lf ? 2'd0 : 2'd1;
		csel[1] = 2'd1;
		csel[2] = geom_s2.rt ? 2'd2 : 2'd1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				g[r][c] = window[4'(rsel[r]) * 4'd3 + 4'(csel[c])];
			end
		end
		// sort each row; the median is the median of the three diagonal picks
		for (int r = 0; r < 3; r++) begin
			r_lo[r] = pmin(pmin(g[r][0], g[r][1]), g[r][2]);
			r_hi[r] = pmax(pmax(g[r][0], g[r][1]), g[r][2]);
			r_md[r] = pmed3(g[r][0], g[r][1], g[r][2]);
		end

		case (mode)
			spmf_pkg::MODE_MED3: begin
				res = pmed3(p_up, p_c, p_rt);
			end
			spmf_pkg::MODE_CROSS5: begin
				res = pmed3(x_hi, x_lo, p_dn);
			end
			spmf_pkg::MODE_BOX9: begin
				res = pmed3(pmax(pmax(r_lo[0], r_lo[1]), r_lo[2]),
				            pmed3(r_md[0], r_md[1], r_md[2]),
				            pmin(pmin(r_hi[0], r_hi[1]), r_hi[2]));
			end
			default: begin
				res = p_c;
			end
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid) begin
			median_value <= res;
			line_end     <= geom_s2.line_end;
			frame_end    <= geom_s2.frame_end;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/selectable_pixel_median_filter.sv -----
// Top level of the selectable pixel median filter: configuration registers and glue.
// Depends on spmf_pkg, spmf_scan, spmf_linebuf, spmf_median and assert_macros.svh.
//
//  channel  dir  signals                                   word
//  s_       in   s_tvalid s_tready s_tdata s_tuser         pixel_value, flush_item
//  m_       out  m_tvalid m_tready m_tdata m_tlast m_tuser median_value, line_end, frame_end
//  cfg_     in   cfg_we cfg_index cfg_wdata                register writes
//
// One word accepted per cycle unless m_ holds the pipeline; a result leaves the output
// register after its releasing word passes the counter stage, line store read and median.
// Results trail the input by one line plus one pixel; a frame ends with image_width + 1
// flush words. Reset needs no clearing pass: store entries are read only once written.
// Backpressure on m_ holds the pipeline; s_tready stays high while the output can drain.
`default_nettype none
`include "assert_macros.svh"

module selectable_pixel_median_filter #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [spmf_pkg::CFG_BITS-1:0]    cfg_wdata,
	// input stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,  // [7:0] pixel_value
	input  wire logic                             s_tuser,  // [0] flush_item
	// output stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [7:0]                       m_tdata,  // [7:0] median_value
	output logic                                  m_tlast,  // line_end
	output logic                                  m_tuser   // [0] frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (CW > spmf_pkg::CFG_BITS) ? CW : spmf_pkg::CFG_BITS;

	spmf_pkg::mode_t                mode_q;
	logic [spmf_pkg::CFG_BITS-1:0]  width_q;
	logic [spmf_pkg::CFG_BITS-1:0]  height_q;
	logic                           restart;

	logic [EW-1:0]                  w_ext;
	logic [CW-1:0]                  eff_width;
	logic [spmf_pkg::CFG_BITS-1:0]  eff_height;

	logic                           in_fire;
	logic                           in_ready;
	logic [AW-1:0]                  rd_addr;
	logic                           s1_valid;
	logic                           s1_fire;
	logic [AW-1:0]                  col_s1;
	spmf_pkg::pix_t                 pix_s1;
	spmf_pkg::geom_t                geom_s1;
	logic                           s2_valid;
	spmf_pkg::geom_t                geom_s2;
	spmf_pkg::win_t                 window;
	logic                           out_free;

	// register writes; any known register restarts the frame
	always_comb begin
		case (spmf_pkg::cfg_idx_t'(cfg_index))
			spmf_pkg::CFG_MODE,
			spmf_pkg::CFG_WIDTH,
			spmf_pkg::CFG_HEIGHT: restart = cfg_we;
			default:              restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= spmf_pkg::MODE_MED3;
			width_q  <= spmf_pkg::WIDTH_RST;
			height_q <= spmf_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (spmf_pkg::cfg_idx_t'(cfg_index))
				spmf_pkg::CFG_MODE:   mode_q   <= spmf_pkg::mode_t'(cfg_wdata[1:0]);
				spmf_pkg::CFG_WIDTH:  width_q  <= cfg_wdata;
				spmf_pkg::CFG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturate width to 1..MAX_WIDTH, height to at least 1
	always_comb begin
		w_ext = EW'(width_q);
		if (width_q == '0) begin
			eff_width = CW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			eff_width = CW'(MAX_WIDTH);
		end else begin
			eff_width = CW'(w_ext);
		end
		eff_height = (height_q == '0) ? spmf_pkg::CFG_BITS'(1) : height_q;
	end

	assign s_tready = in_ready;
	assign in_fire  = s_tvalid && in_ready;

	spmf_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.in_fire     (in_fire),
		.pixel_value (s_tdata),
		.flush_item  (s_tuser),
		.eff_width   (eff_width),
		.eff_height  (eff_height),
		.s1_fire     (s1_fire),
		.in_ready    (in_ready),
		.rd_addr     (rd_addr),
		.s1_valid    (s1_valid),
		.col_s1      (col_s1),
		.pix_s1      (pix_s1),
		.geom_s1     (geom_s1)
	);

	spmf_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.in_fire  (in_fire),
		.rd_addr  (rd_addr),
		.s1_valid (s1_valid),
		.col_s1   (col_s1),
		.pix_s1   (pix_s1),
		.geom_s1  (geom_s1),
		.out_free (out_free),
		.s1_fire  (s1_fire),
		.s2_valid (s2_valid),
		.geom_s2  (geom_s2),
		.window   (window)
	);

	spmf_median u_median (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.s2_valid     (s2_valid),
		.geom_s2      (geom_s2),
		.window       (window),
		.m_tready     (m_tready),
		.out_free     (out_free),
		.m_tvalid     (m_tvalid),
		.median_value (m_tdata),
		.line_end     (m_tlast),
		.frame_end    (m_tuser)
	);

	`SPMF_ASSERT_IMP(a_stall_from_output, !s_tready, m_tvalid)
	`SPMF_ASSERT_IMP(a_frame_ends_line, m_tvalid && m_tuser, m_tlast)

endmodule

`default_nettype wire
